// ===== design/bpr_pkg.sv =====
// bpr_pkg: shared types and codes for the bitmap rotate block.
// No dependencies; imported by the controller, the datapath and the top level.
package bpr_pkg;

    localparam int BYTE_W = 8;
    localparam int PIX_W  = 32;
    localparam int CFG_DW = 9;
    localparam int CFG_IW = 2;

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_FETCH = 1'b1;

    localparam logic FMT_RGB24 = 1'b0;
    localparam logic FMT_RGB32 = 1'b1;

    localparam logic [CFG_IW-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_HEIGHT = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_FORMAT = 2'd2;

    typedef struct packed {
        logic load;
        logic fetch;
        logic capture;
        logic cfg_wr;
    } t_cmd;

endpackage

// ===== design/bpr_ram.sv =====
// bpr_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module bpr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 65536
) (
    input  logic                                       i_clk,
    input  logic                                       i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                           i_wr_data,
    input  logic                                       i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                           o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== design/bpr_ctrl.sv =====
// bpr_ctrl: handshake controller; sequences a fetch through the store read
// and the output register. Depends on bpr_pkg.
module bpr_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_valid,
    input  logic          i_s_func,
    input  logic          i_m_ready,
    input  logic          i_cfg_valid,
    output logic          o_s_ready,
    output logic          o_m_valid,
    output logic          o_cfg_ready,
    output bpr_pkg::t_cmd o_cmd
);
    import bpr_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_HOLD = 2'd2;

    logic [1:0] r_state, n_state;
    logic       r_m_valid, n_m_valid;
    logic       w_accept;
    logic       w_slot_free;
    logic       w_capture;

    assign o_s_ready   = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_s_valid && o_s_ready;
    assign w_slot_free = !r_m_valid || i_m_ready;

    always_comb begin
        n_state   = r_state;
        w_capture = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept && (i_s_func == FUNC_FETCH)) begin
                    n_state = S_READ;
                end
            end
            S_READ, S_HOLD: begin
                if (w_slot_free) begin
                    w_capture = 1'b1;
                    n_state   = S_IDLE;
                end else begin
                    n_state = S_HOLD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_m_valid = r_m_valid;
        if (w_capture) begin
            n_m_valid = 1'b1;
        end else if (i_m_ready) begin
            n_m_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_m_valid <= n_m_valid;
        end
    end

    assign o_m_valid     = r_m_valid;
    assign o_cmd.load    = w_accept && (i_s_func == FUNC_LOAD);
    assign o_cmd.fetch   = w_accept && (i_s_func == FUNC_FETCH);
    assign o_cmd.capture = w_capture;
    assign o_cmd.cfg_wr  = i_cfg_valid && o_cfg_ready;

endmodule

// ===== design/bpr_dpath.sv =====
// bpr_dpath: configuration registers, load/emit counters, frame store and
// output register. Depends on bpr_pkg and bpr_ram.
module bpr_dpath #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  bpr_pkg::t_cmd                      i_cmd,
    input  logic [bpr_pkg::BYTE_W-1:0]         i_data_byte,
    input  logic [bpr_pkg::CFG_IW-1:0]         i_cfg_index,
    input  logic [bpr_pkg::CFG_DW-1:0]         i_cfg_data,
    output logic [bpr_pkg::BYTE_W-1:0]         o_out_byte,
    output logic                               o_frame_ready,
    output logic                               o_last_byte
);
    import bpr_pkg::*;

    localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int WW    = CW + 1;
    localparam int HW    = RW + 1;
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [CFG_DW-1:0] r_cfg_w, r_cfg_h;
    logic              r_fmt;

    logic [CW-1:0] r_ld_col, n_ld_col;
    logic [RW-1:0] r_ld_row, n_ld_row;
    logic [1:0]    r_ld_bidx, n_ld_bidx;
    logic [1:0]    r_ld_pad, n_ld_pad;
    logic [23:0]   r_asm, n_asm;
    logic [CW-1:0] r_em_row, n_em_row;
    logic [RW-1:0] r_em_col, n_em_col;
    logic [1:0]    r_em_bidx, n_em_bidx;
    logic [1:0]    r_em_pad, n_em_pad;
    logic          r_loaded, n_loaded;

    logic [1:0]    r_pend_bidx, n_pend_bidx;
    logic          r_pend_zero, n_pend_zero;
    logic          r_pend_ready, n_pend_ready;
    logic          r_pend_last, n_pend_last;

    logic [BYTE_W-1:0] r_out_byte;
    logic              r_out_ready;
    logic              r_out_last;

    logic [WW-1:0]  w_eff_w;
    logic [HW-1:0]  w_eff_h;
    logic [1:0]     w_last_idx;
    logic           w_wr_en;
    logic [PIX_W-1:0] w_wr_data;
    logic [AW-1:0]  w_wr_addr;
    logic [AW-1:0]  w_rd_addr;
    logic [CW-1:0]  w_rd_col;
    logic [PIX_W-1:0] w_rd_data;
    logic [BYTE_W-1:0] w_sel_byte;

    always_comb begin
        if (r_cfg_w == '0) begin
            w_eff_w = WW'(1);
        end else if (32'(r_cfg_w) > 32'(MAX_WIDTH)) begin
            w_eff_w = WW'(MAX_WIDTH);
        end else begin
            w_eff_w = WW'(r_cfg_w);
        end
        if (r_cfg_h == '0) begin
            w_eff_h = HW'(1);
        end else if (32'(r_cfg_h) > 32'(MAX_HEIGHT)) begin
            w_eff_h = HW'(MAX_HEIGHT);
        end else begin
            w_eff_h = HW'(r_cfg_h);
        end
    end

    assign w_last_idx = (r_fmt == FMT_RGB32) ? 2'd3 : 2'd2;

    // load side
    always_comb begin
        n_ld_col  = r_ld_col;
        n_ld_row  = r_ld_row;
        n_ld_bidx = r_ld_bidx;
        n_ld_pad  = r_ld_pad;
        n_asm     = r_asm;
        n_em_row  = r_em_row;
        n_em_col  = r_em_col;
        n_em_bidx = r_em_bidx;
        n_em_pad  = r_em_pad;
        n_loaded  = r_loaded;
        w_wr_en   = 1'b0;
        w_wr_data = {r_fmt ? i_data_byte : 8'd0,
                     r_fmt ? r_asm[23:16] : i_data_byte, r_asm[15:0]};
        w_wr_addr = AW'(r_ld_col) * AW'(MAX_HEIGHT) + AW'(r_ld_row);

        n_pend_bidx  = r_pend_bidx;
        n_pend_zero  = r_pend_zero;
        n_pend_ready = r_pend_ready;
        n_pend_last  = r_pend_last;

        if (i_cmd.cfg_wr && (i_cfg_index == CFG_WIDTH || i_cfg_index == CFG_HEIGHT
                             || i_cfg_index == CFG_FORMAT)) begin
            n_ld_col  = '0;
            n_ld_row  = '0;
            n_ld_bidx = '0;
            n_ld_pad  = '0;
            n_asm     = '0;
            n_em_row  = '0;
            n_em_col  = '0;
            n_em_bidx = '0;
            n_em_pad  = '0;
            n_loaded  = 1'b0;
        end else if (i_cmd.load) begin
            if (r_loaded) begin
                // new frame: start from cleared counters
                n_ld_col  = '0;
                n_ld_row  = '0;
                n_ld_bidx = '0;
                n_ld_pad  = '0;
                n_asm     = '0;
                n_em_row  = '0;
                n_em_col  = '0;
                n_em_bidx = '0;
                n_em_pad  = '0;
                n_loaded  = 1'b0;
                w_wr_data = {r_fmt ? i_data_byte : 8'd0, 24'd0};
                w_wr_addr = '0;
            end
            if (n_ld_pad != 2'd0) begin
                n_ld_pad = n_ld_pad - 2'd1;
                if (n_ld_pad == 2'd0) begin
                    n_ld_col = '0;
                    if ({1'b0, n_ld_row} == w_eff_h - HW'(1)) begin
                        n_ld_row = '0;
                        n_loaded = 1'b1;
                    end else begin
                        n_ld_row = n_ld_row + RW'(1);
                    end
                end
            end else if (n_ld_bidx < w_last_idx) begin
                case (n_ld_bidx)
                    2'd0:    n_asm[7:0]   = i_data_byte;
                    2'd1:    n_asm[15:8]  = i_data_byte;
                    default: n_asm[23:16] = i_data_byte;
                endcase
                n_ld_bidx = n_ld_bidx + 2'd1;
            end else begin
                w_wr_en   = 1'b1;
                n_asm     = '0;
                n_ld_bidx = '0;
                if ({1'b0, n_ld_col} == w_eff_w - WW'(1)) begin
                    n_ld_col = '0;
                    if ((r_fmt == FMT_RGB24) && (w_eff_w[1:0] != 2'd0)) begin
                        n_ld_pad = w_eff_w[1:0];
                    end else if ({1'b0, n_ld_row} == w_eff_h - HW'(1)) begin
                        n_ld_row = '0;
                        n_loaded = 1'b1;
                    end else begin
                        n_ld_row = n_ld_row + RW'(1);
                    end
                end else begin
                    n_ld_col = n_ld_col + CW'(1);
                end
            end
        end else if (i_cmd.fetch) begin
            n_pend_ready = r_loaded;
            n_pend_zero  = !r_loaded || (r_em_pad != 2'd0);
            n_pend_bidx  = r_em_bidx;
            n_pend_last  = 1'b0;
            if (r_loaded) begin
                if (r_em_pad != 2'd0) begin
                    n_em_pad = r_em_pad - 2'd1;
                    if (n_em_pad == 2'd0) begin
                        n_em_col = '0;
                        if ({1'b0, r_em_row} == w_eff_w - WW'(1)) begin
                            n_em_row    = '0;
                            n_pend_last = 1'b1;
                        end else begin
                            n_em_row = r_em_row + CW'(1);
                        end
                    end
                end else if (r_em_bidx < w_last_idx) begin
                    n_em_bidx = r_em_bidx + 2'd1;
                end else begin
                    n_em_bidx = '0;
                    if ({1'b0, r_em_col} == w_eff_h - HW'(1)) begin
                        n_em_col = '0;
                        if ((r_fmt == FMT_RGB24) && (w_eff_h[1:0] != 2'd0)) begin
                            n_em_pad = w_eff_h[1:0];
                        end else if ({1'b0, r_em_row} == w_eff_w - WW'(1)) begin
                            n_em_row    = '0;
                            n_pend_last = 1'b1;
                        end else begin
                            n_em_row = r_em_row + CW'(1);
                        end
                    end else begin
                        n_em_col = r_em_col + RW'(1);
                    end
                end
            end
        end
    end

    // output row k reads input column width-1-k
    assign w_rd_col  = CW'(w_eff_w - WW'(1) - {1'b0, r_em_row});
    assign w_rd_addr = AW'(w_rd_col) * AW'(MAX_HEIGHT) + AW'(r_em_col);

    bpr_ram #(
        .WIDTH (PIX_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (i_cmd.fetch),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    always_comb begin
        case (r_pend_bidx)
            2'd0:    w_sel_byte = w_rd_data[7:0];
            2'd1:    w_sel_byte = w_rd_data[15:8];
            2'd2:    w_sel_byte = w_rd_data[23:16];
            default: w_sel_byte = w_rd_data[31:24];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w   <= CFG_DW'(1);
            r_cfg_h   <= CFG_DW'(1);
            r_fmt     <= FMT_RGB24;
            r_ld_col  <= '0;
            r_ld_row  <= '0;
            r_ld_bidx <= '0;
            r_ld_pad  <= '0;
            r_asm     <= '0;
            r_em_row  <= '0;
            r_em_col  <= '0;
            r_em_bidx <= '0;
            r_em_pad  <= '0;
            r_loaded  <= 1'b0;
        end else begin
            if (i_cmd.cfg_wr) begin
                unique case (i_cfg_index)
                    CFG_WIDTH:  r_cfg_w <= i_cfg_data;
                    CFG_HEIGHT: r_cfg_h <= i_cfg_data;
                    CFG_FORMAT: r_fmt   <= i_cfg_data[0];
                    default: ;
                endcase
            end
            r_ld_col  <= n_ld_col;
            r_ld_row  <= n_ld_row;
            r_ld_bidx <= n_ld_bidx;
            r_ld_pad  <= n_ld_pad;
            r_asm     <= n_asm;
            r_em_row  <= n_em_row;
            r_em_col  <= n_em_col;
            r_em_bidx <= n_em_bidx;
            r_em_pad  <= n_em_pad;
            r_loaded  <= n_loaded;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_bidx  <= n_pend_bidx;
        r_pend_zero  <= n_pend_zero;
        r_pend_ready <= n_pend_ready;
        r_pend_last  <= n_pend_last;
        if (i_cmd.capture) begin
            r_out_byte  <= r_pend_zero ? '0 : w_sel_byte;
            r_out_ready <= r_pend_ready;
            r_out_last  <= r_pend_last;
        end
    end

    assign o_out_byte    = r_out_byte;
    assign o_frame_ready = r_out_ready;
    assign o_last_byte   = r_out_last;

endmodule

// ===== design/bmp_pixel_array_rotate_90.sv =====
// bmp_pixel_array_rotate_90: top level of the 90-degree bitmap rotator.
// Depends on bpr_pkg, bpr_ctrl, bpr_dpath (which holds bpr_ram).
//
//   channel   dir  handshake                          payload
//   s_axis    in   i_s_axis_tvalid / o_s_axis_tready  tuser=func, tdata=data_byte
//   m_axis    out  o_m_axis_tvalid / i_m_axis_tready  tdata=out_byte, tuser=frame_ready,
//                                                     tlast=last_byte
//   cfg       in   i_cfg_valid / o_cfg_ready          i_cfg_index, i_cfg_data
//
// Loads stream at one per cycle while no fetch is in flight.
// For a fetch word the frame store read port is registered, and the
// input is held off until the read data reaches the output register.
// The output register frees the input side while a result waits.
// Reset is synchronous; the frame store is not cleared and needs no sweep.
module bmp_pixel_array_rotate_90 #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [bpr_pkg::BYTE_W-1:0]    i_s_axis_tdata,  // [7:0] data_byte
    input  logic                          i_s_axis_tuser,  // [0] func
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    output logic [bpr_pkg::BYTE_W-1:0]    o_m_axis_tdata,  // [7:0] out_byte
    output logic                          o_m_axis_tuser,  // [0] frame_ready
    output logic                          o_m_axis_tlast,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [bpr_pkg::CFG_IW-1:0]    i_cfg_index,
    input  logic [bpr_pkg::CFG_DW-1:0]    i_cfg_data
);
    import bpr_pkg::*;

    t_cmd cmd;

    bpr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_valid   (i_s_axis_tvalid),
        .i_s_func    (i_s_axis_tuser),
        .i_m_ready   (i_m_axis_tready),
        .i_cfg_valid (i_cfg_valid),
        .o_s_ready   (o_s_axis_tready),
        .o_m_valid   (o_m_axis_tvalid),
        .o_cfg_ready (o_cfg_ready),
        .o_cmd       (cmd)
    );

    bpr_dpath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_data_byte   (i_s_axis_tdata),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_out_byte    (o_m_axis_tdata),
        .o_frame_ready (o_m_axis_tuser),
        .o_last_byte   (o_m_axis_tlast)
    );

`ifndef SYNTHESIS
    a_fetch_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.fetch |=> !o_s_axis_tready)
        else $error("input accepted while a store read is in flight");

    a_capture_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.capture |-> (!o_m_axis_tvalid || i_m_axis_tready))
        else $error("output register overwritten before it was taken");

    a_capture_not_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.capture |-> !o_s_axis_tready)
        else $error("capture without a pending fetch");

    a_one_command: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.load, cmd.fetch}))
        else $error("load and fetch issued together");

    a_capture_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.capture |=> o_m_axis_tvalid)
        else $error("captured word not presented");
`endif

endmodule

// ===== bench/bpr_rotate_check.sv =====
// bpr_rotate_check: watches the config, input and output channels of the bitmap rotator,
// predicts every output word and compares it field by field with what the block returns.
// Depends on bpr_pkg for widths, function codes, formats and register indexes.
module bpr_rotate_check #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_tvalid,
    input  logic                         i_s_tready,
    input  logic [bpr_pkg::BYTE_W-1:0]   i_s_tdata,
    input  logic                         i_s_tuser,
    input  logic                         i_m_tvalid,
    input  logic                         i_m_tready,
    input  logic [bpr_pkg::BYTE_W-1:0]   i_m_tdata,
    input  logic                         i_m_tuser,
    input  logic                         i_m_tlast,
    input  logic                         i_cfg_valid,
    input  logic                         i_cfg_ready,
    input  logic [bpr_pkg::CFG_IW-1:0]   i_cfg_index,
    input  logic [bpr_pkg::CFG_DW-1:0]   i_cfg_data,
    output int                           o_errors,
    output int                           o_pending
);
    import bpr_pkg::*;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              ready;
        logic              last;
    } t_rot_byte;

    t_rot_byte         rot_bytes_due[$];
    logic [PIX_W-1:0]  pix_mem [MAX_WIDTH][MAX_HEIGHT];

    logic [CFG_DW-1:0] width_reg;
    logic [CFG_DW-1:0] height_reg;
    logic              fmt_reg;

    logic [CFG_DW-1:0] ld_col;
    logic [CFG_DW-1:0] ld_row;
    logic [1:0]        ld_byte;
    logic [1:0]        ld_pad;
    logic [23:0]       pix_acc;
    logic [CFG_DW-1:0] rd_row;
    logic [CFG_DW-1:0] rd_col;
    logic [1:0]        rd_byte;
    logic [1:0]        rd_pad;
    logic              frame_done;
    int                n_checked;

    function automatic logic [CFG_DW-1:0] eff_dim(input logic [CFG_DW-1:0] v, input int lim);
        if (v == 0) return CFG_DW'(1);
        if (v > lim) return CFG_DW'(lim);
        return v;
    endfunction

    // zero bytes that bring n 3-byte pixels to a 4-byte boundary
    function automatic logic [1:0] row_pad(input logic [CFG_DW-1:0] n);
        logic [CFG_DW+1:0] bytes3;
        bytes3 = (CFG_DW+2)'(n) * 3;
        return 2'd0 - bytes3[1:0];
    endfunction

    function automatic void clear_progress();
        ld_col     = '0;
        ld_row     = '0;
        ld_byte    = '0;
        ld_pad     = '0;
        pix_acc    = '0;
        rd_row     = '0;
        rd_col     = '0;
        rd_byte    = '0;
        rd_pad     = '0;
        frame_done = 1'b0;
    endfunction

    function automatic void close_in_row(input logic [CFG_DW-1:0] h);
        ld_col = '0;
        ld_row = ld_row + 1;
        if (ld_row >= h) begin
            ld_row     = '0;
            frame_done = 1'b1;
        end
    endfunction

    function automatic logic close_out_row(input logic [CFG_DW-1:0] w);
        rd_col = '0;
        rd_row = rd_row + 1;
        if (rd_row >= w) begin
            rd_row = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void absorb_byte(input logic [BYTE_W-1:0] b);
        logic [CFG_DW-1:0] w;
        logic [CFG_DW-1:0] h;
        logic [1:0]        top_idx;
        w       = eff_dim(width_reg, MAX_WIDTH);
        h       = eff_dim(height_reg, MAX_HEIGHT);
        top_idx = (fmt_reg == FMT_RGB32) ? 2'd3 : 2'd2;
        // a load after a complete frame starts the next one
        if (frame_done) clear_progress();
        if (ld_pad != 0) begin
            ld_pad = ld_pad - 1;
            if (ld_pad == 0) close_in_row(h);
        end else if (ld_byte < top_idx) begin
            pix_acc = pix_acc | (24'(b) << (8 * ld_byte));
            ld_byte = ld_byte + 1;
        end else begin
            pix_mem[ld_col][ld_row] = {8'h00, pix_acc} | (PIX_W'(b) << (8 * top_idx));
            pix_acc = '0;
            ld_byte = '0;
            ld_col  = ld_col + 1;
            if (ld_col >= w) begin
                if (fmt_reg == FMT_RGB24 && row_pad(w) != 0) begin
                    ld_col = '0;
                    ld_pad = row_pad(w);
                end else begin
                    close_in_row(h);
                end
            end
        end
    endfunction

    function automatic t_rot_byte next_rot_byte();
        t_rot_byte         r;
        logic [CFG_DW-1:0] w;
        logic [CFG_DW-1:0] h;
        logic [1:0]        top_idx;
        logic [PIX_W-1:0]  px;
        r       = '0;
        w       = eff_dim(width_reg, MAX_WIDTH);
        h       = eff_dim(height_reg, MAX_HEIGHT);
        top_idx = (fmt_reg == FMT_RGB32) ? 2'd3 : 2'd2;
        if (!frame_done) return r;
        r.ready = 1'b1;
        if (rd_pad != 0) begin
            rd_pad = rd_pad - 1;
            if (rd_pad == 0) r.last = close_out_row(w);
        end else begin
            // output row k is input column w-1-k
            px     = pix_mem[w - 1 - rd_row][rd_col];
            r.data = px[8 * rd_byte +: 8];
            if (rd_byte < top_idx) begin
                rd_byte = rd_byte + 1;
            end else begin
                rd_byte = '0;
                rd_col  = rd_col + 1;
                if (rd_col >= h) begin
                    if (fmt_reg == FMT_RGB24 && row_pad(h) != 0) begin
                        rd_col = '0;
                        rd_pad = row_pad(h);
                    end else begin
                        r.last = close_out_row(w);
                    end
                end
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_rot_byte exp_b;
        t_rot_byte got_b;
        if (!i_rst_n) begin
            width_reg  = 1;
            height_reg = 1;
            fmt_reg    = FMT_RGB24;
            clear_progress();
            rot_bytes_due.delete();
            o_errors   = 0;
            n_checked  = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_WIDTH: begin
                        width_reg = i_cfg_data;
                        clear_progress();
                    end
                    CFG_HEIGHT: begin
                        height_reg = i_cfg_data;
                        clear_progress();
                    end
                    CFG_FORMAT: begin
                        fmt_reg = i_cfg_data[0];
                        clear_progress();
                    end
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready) begin
                if (i_s_tuser == FUNC_LOAD) absorb_byte(i_s_tdata);
                else rot_bytes_due.push_back(next_rot_byte());
            end
            if (i_m_tvalid && i_m_tready) begin
                got_b.data  = i_m_tdata;
                got_b.ready = i_m_tuser;
                got_b.last  = i_m_tlast;
                if (rot_bytes_due.size() == 0) begin
                    if (o_errors < 10)
                        $display("rotate: out word %0d not expected: data %02h ready %b last %b",
                                 n_checked, got_b.data, got_b.ready, got_b.last);
                    o_errors++;
                end else begin
                    exp_b = rot_bytes_due.pop_front();
                    if (got_b !== exp_b) begin
                        if (o_errors < 10)
                            $display({"rotate: out word %0d expected data %02h ready %b last %b,",
                                      " got data %02h ready %b last %b"},
                                     n_checked, exp_b.data, exp_b.ready, exp_b.last,
                                     got_b.data, got_b.ready, got_b.last);
                        o_errors++;
                    end
                end
                n_checked++;
            end
        end
        o_pending = rot_bytes_due.size();
    end

endmodule

// ===== bench/testbench.sv =====
// testbench: drives load and fetch words into the bitmap rotator over random frame sizes
// and formats, with random idling on both sides; bpr_rotate_check predicts and compares.
// Depends on bpr_pkg, bmp_pixel_array_rotate_90 and bpr_rotate_check.
module testbench;
    import bpr_pkg::*;

    localparam int MAX_W       = 256;
    localparam int MAX_H       = 256;
    localparam int DRAIN       = 8;
    localparam int HOLD_AT     = 100;
    localparam int HOLD_CYCLES = 300;
    localparam int RAND_ITEMS  = 500;

    localparam logic [CFG_IW-1:0] CFG_SPARE = 2'd3;

    typedef enum logic [1:0] {PH_CLEAN, PH_BROKEN, PH_NOISE} t_phase_kind;

    logic              i_clk   = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              s_valid = 1'b0;
    logic [BYTE_W-1:0] s_data  = '0;
    logic              s_user  = 1'b0;
    logic              m_ready = 1'b0;
    logic              c_valid = 1'b0;
    logic [CFG_IW-1:0] c_index = '0;
    logic [CFG_DW-1:0] c_data  = '0;
    logic              s_ready;
    logic              m_valid;
    logic [BYTE_W-1:0] m_data;
    logic              m_user;
    logic              m_last;
    logic              c_ready;
    int                errors;
    int                pending;
    logic              no_idle   = 1'b0;
    int                n_sent    = 0;
    int                n_results = 0;

    always #5 i_clk = ~i_clk;

    bmp_pixel_array_rotate_90 #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user),
        .o_m_axis_tlast  (m_last),
        .i_cfg_valid     (c_valid),
        .o_cfg_ready     (c_ready),
        .i_cfg_index     (c_index),
        .i_cfg_data      (c_data)
    );

    bpr_rotate_check #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) u_rotate_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_valid),
        .i_s_tready  (s_ready),
        .i_s_tdata   (s_data),
        .i_s_tuser   (s_user),
        .i_m_tvalid  (m_valid),
        .i_m_tready  (m_ready),
        .i_m_tdata   (m_data),
        .i_m_tuser   (m_user),
        .i_m_tlast   (m_last),
        .i_cfg_valid (c_valid),
        .i_cfg_ready (c_ready),
        .i_cfg_index (c_index),
        .i_cfg_data  (c_data),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    function automatic int eff_dim(input logic [CFG_DW-1:0] v, input int lim);
        if (v == 0) return 1;
        if (v > lim) return lim;
        return int'(v);
    endfunction

    function automatic int pad4(input int n);
        return (4 - (n * 3) % 4) % 4;
    endfunction

    task automatic send_word(input logic func, input logic [BYTE_W-1:0] b);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_user  <= func;
        s_data  <= b;
        do @(posedge i_clk); while (!s_ready);
        n_sent++;
    endtask

    task automatic cfg_write(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] val);
        c_valid <= 1'b1;
        c_index <= idx;
        c_data  <= val;
        do @(posedge i_clk); while (!c_ready);
    endtask

    // lets every expected word arrive, then waits out trailing loads
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge i_clk);
        wait (pending == 0);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    task automatic configure(input logic [CFG_DW-1:0] w_reg, input logic [CFG_DW-1:0] h_reg,
                             input logic fmt);
        if ($urandom_range(0, 3) == 0) cfg_write(CFG_SPARE, CFG_DW'($urandom));
        cfg_write(CFG_WIDTH, w_reg);
        cfg_write(CFG_HEIGHT, h_reg);
        cfg_write(CFG_FORMAT, {8'($urandom), fmt});
        c_valid <= 1'b0;
    endtask

    task automatic run_phase(input logic [CFG_DW-1:0] w_reg, input logic [CFG_DW-1:0] h_reg,
                             input logic fmt, input t_phase_kind kind, input int fetch_cap);
        int w;
        int h;
        int bpp;
        int n_in;
        int n_out;
        int n_fetch;
        int k;
        settle();
        configure(w_reg, h_reg, fmt);
        no_idle = ($urandom_range(0, 3) == 0);
        w     = eff_dim(w_reg, MAX_W);
        h     = eff_dim(h_reg, MAX_H);
        bpp   = (fmt == FMT_RGB32) ? 4 : 3;
        n_in  = h * (w * bpp + ((fmt == FMT_RGB32) ? 0 : pad4(w)));
        n_out = w * (h * bpp + ((fmt == FMT_RGB32) ? 0 : pad4(h)));
        case (kind)
            PH_CLEAN: begin
                k = 0;
                while (k < n_in) begin
                    if ($urandom_range(0, 15) == 0) begin
                        send_word(FUNC_FETCH, 8'($urandom));
                    end else begin
                        send_word(FUNC_LOAD, 8'($urandom));
                        k++;
                    end
                end
                if ($urandom_range(0, 4) == 0) n_fetch = $urandom_range(1, n_out);
                else n_fetch = n_out + $urandom_range(0, n_out / 2 + 2);
                if (n_fetch > fetch_cap) n_fetch = fetch_cap;
                repeat (n_fetch) send_word(FUNC_FETCH, 8'($urandom));
                if ($urandom_range(0, 3) == 0) begin
                    repeat ($urandom_range(1, 4)) send_word(FUNC_LOAD, 8'($urandom));
                    send_word(FUNC_FETCH, 8'($urandom));
                end
            end
            PH_BROKEN: begin
                repeat ($urandom_range(1, n_in))
                    send_word(($urandom_range(0, 3) == 0) ? FUNC_FETCH : FUNC_LOAD, 8'($urandom));
            end
            default: begin
                repeat ($urandom_range(5, 30)) send_word(1'($urandom), 8'($urandom));
            end
        endcase
    endtask

    initial begin
        #4_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin : rx_side
        int gap;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            gap = no_idle ? 0 : $urandom_range(0, 6);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_ready <= 1'b1;
            do @(posedge i_clk); while (!m_valid);
            n_results++;
            // long back-pressure so the output register fills and the input stalls
            if (n_results == HOLD_AT) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
        end
    end

    initial begin : stim
        int          ph;
        int          mark;
        int          n_rand;
        t_phase_kind kind;
        int          r;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // 1x1 24-bit frame after reset
        send_word(FUNC_FETCH, 8'h00);
        send_word(FUNC_LOAD, 8'hFF);
        send_word(FUNC_LOAD, 8'h00);
        settle();
        cfg_write(CFG_SPARE, 9'h1FF);
        c_valid <= 1'b0;
        send_word(FUNC_LOAD, 8'hA5);
        send_word(FUNC_LOAD, 8'h5A);
        repeat (5) send_word(FUNC_FETCH, 8'hFF);
        send_word(FUNC_LOAD, 8'h12);
        send_word(FUNC_FETCH, 8'h00);

        ph     = 0;
        n_rand = 0;
        while (n_rand < RAND_ITEMS) begin
            mark = n_sent;
            if (ph == 1) begin
                run_phase(9'd0, 9'd0, FMT_RGB32, PH_CLEAN, 64);
            end else begin
                r   = $urandom_range(0, 9);
                kind = (r < 7) ? PH_CLEAN : ((r < 9) ? PH_BROKEN : PH_NOISE);
                run_phase(($urandom_range(0, 9) == 0) ? 9'd0 : 9'($urandom_range(1, 6)),
                          ($urandom_range(0, 9) == 0) ? 9'd0 : 9'($urandom_range(1, 6)),
                          1'($urandom), kind, 1000);
            end
            n_rand += n_sent - mark;
            ph++;
        end

        settle();
        if (errors == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== bmp_pixel_array_rotate_90.f =====
design/bpr_pkg.sv
design/bpr_ram.sv
design/bpr_ctrl.sv
design/bpr_dpath.sv
design/bmp_pixel_array_rotate_90.sv
bench/bpr_rotate_check.sv
bench/testbench.sv
